// ===== hdl/lfga_pkg.sv =====
// ----------------------------------------------------------------------------
// lfga_pkg
// Shared types and constants for the lowest free gate allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package lfga_pkg;

  localparam int unsigned CFG_W      = 7;
  localparam int unsigned GATE_OUT_W = 6;

  localparam logic [CFG_W-1:0] GATES_IN_USE_RESET = 7'd64;

  typedef struct packed {
    logic advance;
    logic start_of_run;
  } bank_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/lfga_req_if.sv =====
// ----------------------------------------------------------------------------
// lfga_req_if
// Request channel: start-of-run mark, arrival time and departure time.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfga_req_if #(
  parameter int unsigned TIME_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic                  start_of_run;
  logic [TIME_WIDTH-1:0] arrival_time;
  logic [TIME_WIDTH-1:0] departure_time;

  modport source (output valid, output start_of_run, output arrival_time,
                  output departure_time, input ready);
  modport sink   (input valid, input start_of_run, input arrival_time,
                  input departure_time, output ready);
endinterface

`default_nettype wire

// ===== hdl/lfga_res_if.sv =====
// ----------------------------------------------------------------------------
// lfga_res_if
// Result channel: grant flag and assigned gate number.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfga_res_if;
  logic                              valid;
  logic                              ready;
  logic                              granted;
  logic [lfga_pkg::GATE_OUT_W-1:0]   gate_index;

  modport source (output valid, output granted, output gate_index, input ready);
  modport sink   (input valid, input granted, input gate_index, output ready);
endinterface

`default_nettype wire

// ===== hdl/lfga_cfg_if.sv =====
// ----------------------------------------------------------------------------
// lfga_cfg_if
// Configuration write channel for the number of gates in use.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfga_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lfga_pkg::CFG_W-1:0]   gates_in_use;

  modport source (output valid, output gates_in_use, input ready);
  modport sink   (input valid, input gates_in_use, output ready);
endinterface

`default_nettype wire

// ===== hdl/lfga_prio_enc.sv =====
// ----------------------------------------------------------------------------
// lfga_prio_enc
// Finds the lowest set bit of a candidate vector as a one-hot mask and index.
// ----------------------------------------------------------------------------
`default_nettype none

module lfga_prio_enc #(
  parameter int unsigned N     = 64,
  parameter int unsigned IDX_W = 6
) (
  input  wire logic [N-1:0]     cand_i,
  output logic                  found_o,
  output logic [N-1:0]          onehot_o,
  output logic [IDX_W-1:0]      idx_o
);

  assign found_o  = |cand_i;
  assign onehot_o = cand_i & ~(cand_i - N'(1));

  always_comb begin
    idx_o = '0;
    for (int g = 0; g < int'(N); g++) begin
      if (onehot_o[g]) begin
        idx_o = idx_o | IDX_W'(g);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lfga_gate_bank.sv =====
// ----------------------------------------------------------------------------
// lfga_gate_bank
// Gate busy flags and release times, with the release compare and the
// lowest-free-gate choice for the request held in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfga_gate_bank #(
  parameter int unsigned NUM_GATES  = 64,
  parameter int unsigned TIME_WIDTH = 32,
  parameter int unsigned IDX_W      = 6
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lfga_pkg::bank_ctrl_t         ctrl_i,
  input  wire logic [TIME_WIDTH-1:0]        arrival_time_i,
  input  wire logic [TIME_WIDTH-1:0]        departure_time_i,
  input  wire logic [lfga_pkg::CFG_W-1:0]   gates_in_use_i,
  output logic                              found_o,
  output logic [IDX_W-1:0]                  idx_o
);

  logic [NUM_GATES-1:0]  busy_q, busy_d;
  logic [TIME_WIDTH-1:0] release_q [NUM_GATES];
  logic [NUM_GATES-1:0]  still_busy;
  logic [NUM_GATES-1:0]  cand;
  logic [NUM_GATES-1:0]  onehot;

  always_comb begin
    for (int g = 0; g < int'(NUM_GATES); g++) begin
      still_busy[g] = busy_q[g] && !ctrl_i.start_of_run &&
                      !(release_q[g] < arrival_time_i);
      cand[g]       = !still_busy[g] && (g < int'(gates_in_use_i));
    end
  end

  lfga_prio_enc #(
    .N     (NUM_GATES),
    .IDX_W (IDX_W)
  ) u_prio_enc (
    .cand_i   (cand),
    .found_o  (found_o),
    .onehot_o (onehot),
    .idx_o    (idx_o)
  );

  assign busy_d = still_busy | onehot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else if (ctrl_i.advance) begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance && found_o) begin
      release_q[idx_o] <= departure_time_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lowest_free_gate_allocator.sv =====
// ----------------------------------------------------------------------------
// lowest_free_gate_allocator
// Grants each request the lowest-numbered free gate after releasing gates
// whose stored departure time is strictly before the request's arrival (all gates at a start of run).
// Path: an accepted request is held in the input register, and its result in the output register.
// Throughput: one item per cycle while the result channel is not stalled, set by the combinational
// release compare and priority encoder feeding the gate state registers.
// Reset: all gates free, gates_in_use set to 64, both pipeline stages empty.
// Release times are not reset; an entry is read only after it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module lowest_free_gate_allocator #(
  parameter int unsigned NUM_GATES  = 64,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lfga_cfg_if.sink    cfg_i,
  lfga_req_if.sink    req_i,
  lfga_res_if.source  res_o
);

  localparam int unsigned IDX_W = (NUM_GATES > 1) ? $clog2(NUM_GATES) : 1;

  logic [lfga_pkg::CFG_W-1:0]      gates_in_use_q;

  logic                            req_valid_q;
  logic                            start_q;
  logic [TIME_WIDTH-1:0]           arrival_q;
  logic [TIME_WIDTH-1:0]           departure_q;

  logic                            res_valid_q;
  logic                            granted_q;
  logic [lfga_pkg::GATE_OUT_W-1:0] gate_index_q;

  logic                            advance;
  logic                            found;
  logic [IDX_W-1:0]                idx;
  logic [IDX_W+lfga_pkg::GATE_OUT_W-1:0] idx_ext;
  lfga_pkg::bank_ctrl_t            bank_ctrl;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gates_in_use_q <= lfga_pkg::GATES_IN_USE_RESET;
    end else if (cfg_i.valid) begin
      gates_in_use_q <= cfg_i.gates_in_use;
    end
  end

  assign advance     = req_valid_q && (!res_valid_q || res_o.ready);
  assign req_i.ready = !req_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      req_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      start_q     <= req_i.start_of_run;
      arrival_q   <= req_i.arrival_time;
      departure_q <= req_i.departure_time;
    end
  end

  assign bank_ctrl.advance      = advance;
  assign bank_ctrl.start_of_run = start_q;

  lfga_gate_bank #(
    .NUM_GATES  (NUM_GATES),
    .TIME_WIDTH (TIME_WIDTH),
    .IDX_W      (IDX_W)
  ) u_gate_bank (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (bank_ctrl),
    .arrival_time_i   (arrival_q),
    .departure_time_i (departure_q),
    .gates_in_use_i   (gates_in_use_q),
    .found_o          (found),
    .idx_o            (idx)
  );

  assign idx_ext = {{lfga_pkg::GATE_OUT_W{1'b0}}, idx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      granted_q    <= found;
      gate_index_q <= idx_ext[lfga_pkg::GATE_OUT_W-1:0];
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.granted    = granted_q;
  assign res_o.gate_index = gate_index_q;

endmodule

`default_nettype wire

// ===== test/tb_lowest_free_gate_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lowest_free_gate_allocator
// Self-checking bench for the lowest free gate allocator. Requests go in from
// a queue through a clocked driver. A clocked monitor compares every result
// with a grant predicted in the bench, under several gate counts and
// handshake idling patterns.
// ----------------------------------------------------------------------------

module tb_lowest_free_gate_allocator;

  localparam int unsigned NUM_GATES    = 64;
  localparam int unsigned TIME_WIDTH   = 32;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic                  start_of_run;
    logic [TIME_WIDTH-1:0] arrival_time;
    logic [TIME_WIDTH-1:0] departure_time;
  } gate_req_t;

  typedef struct packed {
    logic                            granted;
    logic [lfga_pkg::GATE_OUT_W-1:0] gate_index;
  } gate_grant_t;

  logic clk;
  logic rst_n;

  lfga_req_if #(.TIME_WIDTH(TIME_WIDTH)) req_bus ();
  lfga_res_if                            res_bus ();
  lfga_cfg_if                            cfg_bus ();

  lowest_free_gate_allocator #(
    .NUM_GATES  (NUM_GATES),
    .TIME_WIDTH (TIME_WIDTH)
  ) DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .req_i  (req_bus),
    .res_o  (res_bus)
  );

  gate_req_t   pending_requests [$];
  gate_grant_t expected_grants  [$];

  bit                         gate_busy    [NUM_GATES];
  logic [TIME_WIDTH-1:0]      gate_release [NUM_GATES];
  logic [lfga_pkg::CFG_W-1:0] gates_cfg;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          req_taken     = 1'b0;
  bit          hold_go       = 1'b0;
  bit          hold_done     = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;
  int unsigned error_count   = 0;
  int unsigned sent_count    = 0;
  int unsigned grant_count   = 0;
  int unsigned refuse_count  = 0;
  int unsigned cfg_count     = 0;
  int unsigned top_gate      = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic gate_grant_t predict_gate_grant(input gate_req_t r);
    gate_grant_t g;
    int unsigned lim;
    bit          found;
    g     = '0;
    found = 1'b0;
    if (r.start_of_run) begin
      for (int k = 0; k < NUM_GATES; k++) gate_busy[k] = 1'b0;
    end
    for (int k = 0; k < NUM_GATES; k++) begin
      if (gate_busy[k] && (gate_release[k] < r.arrival_time)) gate_busy[k] = 1'b0;
    end
    lim = (gates_cfg > NUM_GATES) ? NUM_GATES : gates_cfg;
    for (int k = 0; k < lim; k++) begin
      if (!found && !gate_busy[k]) begin
        found           = 1'b1;
        gate_busy[k]    = 1'b1;
        gate_release[k] = r.departure_time;
        g.granted       = 1'b1;
        g.gate_index    = k[lfga_pkg::GATE_OUT_W-1:0];
      end
    end
    return g;
  endfunction

  always @(negedge clk) begin
    gate_req_t nxt;
    if (rst_n) begin
      if (!req_bus.valid || req_taken) begin
        if ((pending_requests.size() != 0) && ($urandom_range(99) >= send_idle_pct)) begin
          nxt                    = pending_requests.pop_front();
          req_bus.valid          <= 1'b1;
          req_bus.start_of_run   <= nxt.start_of_run;
          req_bus.arrival_time   <= nxt.arrival_time;
          req_bus.departure_time <= nxt.departure_time;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    gate_req_t   r;
    gate_grant_t exp_g;
    if (rst_n) begin
      req_taken <= req_bus.valid && req_bus.ready;
      if (cfg_bus.valid && cfg_bus.ready) gates_cfg = cfg_bus.gates_in_use;
      if (res_bus.valid && res_bus.ready) begin
        if (res_bus.granted) begin
          grant_count++;
          if (res_bus.gate_index > top_gate) top_gate = res_bus.gate_index;
        end else begin
          refuse_count++;
        end
        if (expected_grants.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result granted=%0b gate_index=%0d", $time,
                   res_bus.granted, res_bus.gate_index);
        end else begin
          exp_g = expected_grants.pop_front();
          if (res_bus.granted !== exp_g.granted) begin
            error_count++;
            $display("%0t: granted mismatch, expected %0b, actual %0b", $time,
                     exp_g.granted, res_bus.granted);
          end
          if (res_bus.gate_index !== exp_g.gate_index) begin
            error_count++;
            $display("%0t: gate_index mismatch, expected %0d, actual %0d", $time,
                     exp_g.gate_index, res_bus.gate_index);
          end
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        r.start_of_run   = req_bus.start_of_run;
        r.arrival_time   = req_bus.arrival_time;
        r.departure_time = req_bus.departure_time;
        expected_grants.push_back(predict_gate_grant(r));
        sent_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_grants.size());
      $display("tb_lowest_free_gate_allocator: done, errors");
      $finish;
    end
  end

  task automatic push_request(input logic sor, input logic [TIME_WIDTH-1:0] arr,
                              input logic [TIME_WIDTH-1:0] dep);
    gate_req_t r;
    r.start_of_run   = sor;
    r.arrival_time   = arr;
    r.departure_time = dep;
    pending_requests.push_back(r);
  endtask

  // A run opens with a start-of-run mark and keeps arrivals non-decreasing.
  // With noise on, some items get a departure before their arrival or are
  // fully random.
  task automatic queue_run(input int n, input int unsigned span_max,
                           input int unsigned step_max, input bit noisy);
    logic [TIME_WIDTH-1:0] t;
    logic [TIME_WIDTH-1:0] d;
    int unsigned           roll;
    t = $urandom;
    for (int i = 0; i < n; i++) begin
      t    = t + $urandom_range(step_max);
      d    = t + $urandom_range(span_max);
      roll = $urandom_range(99);
      if (noisy && (roll < 5)) begin
        push_request(1'($urandom_range(1)), $urandom, $urandom);
      end else if (noisy && (roll < 10)) begin
        push_request(i == 0, t, t - $urandom_range(50));
      end else begin
        push_request(i == 0, t, d);
      end
    end
  endtask

  task automatic queue_phase(input int total, input int unsigned span_max,
                             input int unsigned step_max);
    int n;
    while (total > 0) begin
      n = $urandom_range(30, 8);
      if (n > total) n = total;
      queue_run(n, span_max, step_max, 1'b1);
      total -= n;
    end
  endtask

  task automatic wait_drained;
    do @(negedge clk);
    while ((pending_requests.size() != 0) || req_bus.valid || (expected_grants.size() != 0));
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_gates_in_use(input logic [lfga_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid        <= 1'b1;
    cfg_bus.gates_in_use <= value;
    do @(posedge clk);
    while (!(cfg_bus.valid && cfg_bus.ready));
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    cfg_count++;
  endtask

  initial begin
    rst_n                  = 1'b0;
    req_bus.valid          = 1'b0;
    req_bus.start_of_run   = 1'b0;
    req_bus.arrival_time   = '0;
    req_bus.departure_time = '0;
    res_bus.ready          = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.gates_in_use   = '0;
    gates_cfg              = lfga_pkg::GATES_IN_USE_RESET;
    for (int k = 0; k < NUM_GATES; k++) begin
      gate_busy[k]    = 1'b0;
      gate_release[k] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 28;
    recv_idle_pct = 84;
    push_request(1'b1, 32'h0000_0000, 32'h0000_0000);
    push_request(1'b0, 32'h0000_0000, 32'h0000_0000);
    push_request(1'b0, 32'h0000_0001, 32'hFFFF_FFFF);
    push_request(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
    push_request(1'b0, 32'h0000_0005, 32'h0000_000A);
    push_request(1'b0, 32'h0000_000B, 32'h0000_0014);
    push_request(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(1'b1, 32'h0000_0000, 32'hAAAA_AAAA);
    push_request(1'b0, 32'h0000_0000, 32'h5555_5555);
    push_request(1'b0, 32'h5555_5555, 32'h0000_0003);
    push_request(1'b0, 32'h5555_5556, 32'h0000_0000);
    push_request(1'b0, 32'hAAAA_AAAB, 32'hAAAA_AAAB);
    push_request(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_phase(60, 40, 4);
    wait_drained();

    write_gates_in_use(7'd0);
    queue_phase(30, 40, 4);
    wait_drained();

    send_idle_pct = 84;
    recv_idle_pct = 28;
    write_gates_in_use(7'd1);
    queue_phase(70, 6, 4);
    wait_drained();

    write_gates_in_use(7'd127);
    queue_run(80, 1000000, 3, 1'b0);
    queue_phase(20, 100, 3);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_gates_in_use(7'd5);
    queue_phase(80, 20, 5);
    hold_go = 1'b1;
    wait_drained();

    write_gates_in_use(7'd64);
    queue_phase(60, 200, 3);
    wait_drained();

    write_gates_in_use(lfga_pkg::CFG_W'($urandom_range(63, 2)));
    queue_phase(60, 60, 3);
    wait_drained();

    $display("Sent %0d requests under %0d register writes plus the reset setting.",
             sent_count, cfg_count);
    $display("Results: %0d granted, %0d refused, highest gate granted %0d.",
             grant_count, refuse_count, top_gate);
    if (error_count == 0) begin
      $display("tb_lowest_free_gate_allocator: done, clean");
    end else begin
      $display("tb_lowest_free_gate_allocator: done, errors");
    end
    $finish;
  end

endmodule
